// ===== rtl/core/union_find_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Union-find engine assertion macros
// Concurrent assertion forms shared by the union-find engine RTL; defining
// ASSERT_OFF leaves every use empty.
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_ENGINE_MACROS_SVH
`define UNION_FIND_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF

// When cond holds at a clock edge, prop must hold at the same edge.
`define UFE_ASSERT_SAME(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("union_find_engine assertion failed");

// When cond holds at a clock edge, prop must hold at the next edge.
`define UFE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("union_find_engine assertion failed");

`else

`define UFE_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define UFE_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ===== rtl/core/ufe_pkg.sv =====
// ----------------------------------------------------------------------------
// Union-find engine package
// Element count, field widths, operation codes and the request and result
// types shared by the engine and its users.
// ----------------------------------------------------------------------------
package ufe_pkg;

	localparam int NODES  = 1024;
	localparam int IDX_W  = 10;
	localparam int SIZE_W = 11;
	localparam int CNT_W  = 10;
	localparam int NIU_W  = 11;

	localparam logic [1:0] OP_UNION = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_FIND  = 2'd2;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [IDX_W-1:0] x;
		logic [IDX_W-1:0] y;
	} request_t;

	typedef struct packed {
		logic             status;
		logic             same_set;
		logic             merged;
		logic [IDX_W-1:0] root_x;
		logic [IDX_W-1:0] root_y;
		logic [NIU_W-1:0] components;
	} result_t;

endpackage

// ===== rtl/core/union_find_engine.sv =====
// A rejected request goes straight to the result; a find-root walks the parent path of x; a
// query or a union within one set walks the paths of x and then y; a union of two sets then
// also reads both set sizes and merges the two sets before the result is loaded.
// One request is in flight at a time, so the next one is taken at the earliest at the
// edge that ends the done cycle; the receiver cannot stall the one-cycle done strobe.
// After reset a clearing pass initializes every entry of both memories; busy is high.
// ----------------------------------------------------------------------------
// Union-find engine
// Disjoint-set forest with union by size, held in a parent memory and a set
// size memory, each read and written back by a small sequencer.
// ----------------------------------------------------------------------------
`include "union_find_engine_macros.svh"

module union_find_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  ufe_pkg::request_t         request,
	output logic                      done,
	output ufe_pkg::result_t          result,
	input  logic                      cfg_we,
	input  logic [ufe_pkg::NIU_W-1:0] cfg_wdata
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_WALKX = 3'd2;
	localparam logic [2:0] ST_WALKY = 3'd3;
	localparam logic [2:0] ST_SIZEX = 3'd4;
	localparam logic [2:0] ST_SIZEY = 3'd5;
	localparam logic [2:0] ST_MERGE = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	localparam logic [ufe_pkg::IDX_W-1:0] LAST_IDX = ufe_pkg::IDX_W'(ufe_pkg::NODES - 1);
	localparam logic [ufe_pkg::NIU_W-1:0] NODES_N  = ufe_pkg::NIU_W'(ufe_pkg::NODES);
	localparam logic [ufe_pkg::CNT_W-1:0] CNT_MAX  = '1;
	localparam logic [ufe_pkg::SIZE_W-1:0] SIZE_MAX = '1;

	logic [2:0] state_q;
	logic [ufe_pkg::IDX_W-1:0] clr_q;
	logic [ufe_pkg::NIU_W-1:0] niu_q;
	logic [ufe_pkg::CNT_W-1:0] merges_q;

	logic [1:0]                 op_q;
	logic [ufe_pkg::IDX_W-1:0]  y_q;
	logic [ufe_pkg::IDX_W-1:0]  cur_q;
	logic [ufe_pkg::IDX_W-1:0]  rx_q;
	logic [ufe_pkg::IDX_W-1:0]  ry_q;
	logic [ufe_pkg::SIZE_W-1:0] s1_q;
	logic                       bad_q;
	logic                       same_q;
	logic                       merged_q;

	logic                    done_q;
	ufe_pkg::result_t        result_q;

	logic [ufe_pkg::IDX_W-1:0]  par_mem [ufe_pkg::NODES];
	logic [ufe_pkg::SIZE_W-1:0] size_mem [ufe_pkg::NODES];

	logic [ufe_pkg::IDX_W-1:0]  par_raddr, par_rdata, par_waddr, par_wdata;
	logic                       par_we;
	logic [ufe_pkg::IDX_W-1:0]  size_raddr, size_waddr;
	logic [ufe_pkg::SIZE_W-1:0] size_rdata, size_wdata;
	logic                       size_we;

	logic                         accept;
	logic [ufe_pkg::NIU_W-1:0]    lim;
	logic                         bad;
	logic                         at_root;
	logic                         x_wins;
	logic [ufe_pkg::SIZE_W:0]     size_sum;
	logic [ufe_pkg::SIZE_W-1:0]   size_sat;
	logic [ufe_pkg::IDX_W-1:0]    winner, loser;
	logic [ufe_pkg::NIU_W-1:0]    merges_ext;

	assign accept  = start && !busy;
	assign busy    = (state_q != ST_IDLE);
	assign lim     = (niu_q > NODES_N) ? NODES_N : niu_q;
	assign bad     = ({1'b0, request.x} >= lim) ||
	                 ((request.opcode != ufe_pkg::OP_FIND) && ({1'b0, request.y} >= lim));
	assign at_root = (par_rdata == cur_q);

	// Union by size: the strictly larger set keeps its root, a tie keeps y's root.
	assign x_wins   = (s1_q > size_rdata);
	assign size_sum = {1'b0, s1_q} + {1'b0, size_rdata};
	assign size_sat = size_sum[ufe_pkg::SIZE_W] ? SIZE_MAX : size_sum[ufe_pkg::SIZE_W-1:0];
	assign winner   = x_wins ? rx_q : ry_q;
	assign loser    = x_wins ? ry_q : rx_q;
	assign merges_ext = {1'b0, merges_q};

	// Memory port control
	always_comb begin
		if (state_q == ST_IDLE) begin
			par_raddr = request.x;
		end else if ((state_q == ST_WALKX) && at_root) begin
			par_raddr = y_q;
		end else begin
			par_raddr = par_rdata;
		end
		size_raddr = (state_q == ST_SIZEY) ? ry_q : rx_q;

		par_we     = (state_q == ST_CLEAR) || (state_q == ST_MERGE);
		size_we    = par_we;
		if (state_q == ST_CLEAR) begin
			par_waddr  = clr_q;
			par_wdata  = clr_q;
			size_waddr = clr_q;
			size_wdata = ufe_pkg::SIZE_W'(1);
		end else begin
			par_waddr  = loser;
			par_wdata  = winner;
			size_waddr = winner;
			size_wdata = size_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			par_mem[par_waddr] <= par_wdata;
		end
		par_rdata <= par_mem[par_raddr];
	end

	always_ff @(posedge clk) begin
		if (size_we) begin
			size_mem[size_waddr] <= size_wdata;
		end
		size_rdata <= size_mem[size_raddr];
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			niu_q <= NODES_N;
		end else if (cfg_we) begin
			niu_q <= cfg_wdata;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			merges_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= bad ? ST_FIN : ST_WALKX;
					end
				end
				ST_WALKX: begin
					if (at_root) begin
						state_q <= (op_q == ufe_pkg::OP_FIND) ? ST_FIN : ST_WALKY;
					end
				end
				ST_WALKY: begin
					if (at_root) begin
						if ((op_q == ufe_pkg::OP_UNION) && (cur_q != rx_q)) begin
							state_q <= ST_SIZEX;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SIZEX: begin
					state_q <= ST_SIZEY;
				end
				ST_SIZEY: begin
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					state_q <= ST_FIN;
					if (merges_q != CNT_MAX) begin
						merges_q <= merges_q + 1'b1;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the request in flight
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q     <= request.opcode;
					y_q      <= request.y;
					cur_q    <= request.x;
					bad_q    <= bad;
					rx_q     <= '0;
					ry_q     <= '0;
					same_q   <= 1'b0;
					merged_q <= 1'b0;
				end
			end
			ST_WALKX: begin
				if (at_root) begin
					rx_q  <= cur_q;
					cur_q <= y_q;
				end else begin
					cur_q <= par_rdata;
				end
			end
			ST_WALKY: begin
				if (at_root) begin
					ry_q   <= cur_q;
					same_q <= (cur_q == rx_q);
				end else begin
					cur_q <= par_rdata;
				end
			end
			ST_SIZEY: begin
				s1_q <= size_rdata;
			end
			ST_MERGE: begin
				rx_q     <= winner;
				ry_q     <= winner;
				merged_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Result register, loaded once the merge count is settled
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			result_q.status     <= bad_q;
			result_q.same_set   <= same_q;
			result_q.merged     <= merged_q;
			result_q.root_x     <= rx_q;
			result_q.root_y     <= ry_q;
			result_q.components <= (niu_q > merges_ext) ? (niu_q - merges_ext) : '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`UFE_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)
	`UFE_ASSERT_SAME(a_done_idle, clk, arst_n, done, state_q == ST_IDLE)
	`UFE_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`UFE_ASSERT_SAME(a_merge_distinct, clk, arst_n, state_q == ST_MERGE, rx_q != ry_q)
	`UFE_ASSERT_SAME(a_merged_roots, clk, arst_n, done && result.merged,
		!result.status && (result.root_x == result.root_y))

endmodule

// ===== tb/tb_union_find_engine.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Union-find engine testbench
// Sends union, same-set and find-root requests through the start/busy
// handshake and predicts every result with a local disjoint-set forest. The
// directed tests cover the tie rule, both merge directions, unions within one
// set, the unused opcode and the index limits. Random phases then run under
// several nodes_in_use settings, with and without gaps between requests.
// ----------------------------------------------------------------------------
module tb_union_find_engine;

	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 40;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	ufe_pkg::request_t         request;
	logic                      done;
	ufe_pkg::result_t          result;
	logic                      cfg_we;
	logic [ufe_pkg::NIU_W-1:0] cfg_wdata;

	// Predicted forest.
	logic [ufe_pkg::IDX_W-1:0]  forest_parent [ufe_pkg::NODES];
	logic [ufe_pkg::SIZE_W-1:0] forest_size [ufe_pkg::NODES];
	logic [ufe_pkg::CNT_W-1:0]  forest_merges;
	logic [ufe_pkg::NIU_W-1:0]  forest_in_use;

	ufe_pkg::result_t expected_results [$];

	int errors;
	int requests_sent;
	int results_checked;
	int merges_seen;
	int rejects_seen;
	int settings_used;
	int cycle_count;
	int gap_limit;

	union_find_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** union_find_engine: FAILED **");
			$finish;
		end
	end

	function automatic logic [ufe_pkg::IDX_W-1:0] root_of(logic [ufe_pkg::IDX_W-1:0] e);
		int steps;
		steps = 0;
		while (steps < ufe_pkg::NODES && forest_parent[e] != e) begin
			e = forest_parent[e];
			steps++;
		end
		return e;
	endfunction

	// Applies one request to the predicted forest and returns its result.
	function automatic ufe_pkg::result_t apply_request(ufe_pkg::request_t rq);
		ufe_pkg::result_t          r;
		int                        lim;
		logic [ufe_pkg::IDX_W-1:0] rx;
		logic [ufe_pkg::IDX_W-1:0] ry;
		logic [ufe_pkg::SIZE_W:0]  sum;
		r = '0;
		lim = (forest_in_use > ufe_pkg::NODES) ? ufe_pkg::NODES : int'(forest_in_use);
		if (int'(rq.x) >= lim ||
			(rq.opcode != ufe_pkg::OP_FIND && int'(rq.y) >= lim)) begin
			r.status = 1'b1;
		end else begin
			rx = root_of(rq.x);
			if (rq.opcode != ufe_pkg::OP_FIND) begin
				ry = root_of(rq.y);
				r.same_set = (rx == ry);
				if (rq.opcode == ufe_pkg::OP_UNION && rx != ry) begin
					sum = forest_size[rx] + forest_size[ry];
					if (sum[ufe_pkg::SIZE_W])
						sum = {1'b0, {ufe_pkg::SIZE_W{1'b1}}};
					if (forest_size[rx] > forest_size[ry]) begin
						forest_parent[ry] = rx;
						forest_size[rx] = sum[ufe_pkg::SIZE_W-1:0];
						ry = rx;
					end else begin
						forest_parent[rx] = ry;
						forest_size[ry] = sum[ufe_pkg::SIZE_W-1:0];
						rx = ry;
					end
					if (forest_merges != '1)
						forest_merges++;
					r.merged = 1'b1;
				end
				r.root_y = ry;
			end
			r.root_x = rx;
		end
		r.components = (forest_in_use > forest_merges) ? forest_in_use - forest_merges : '0;
		return r;
	endfunction

	// Every done strobe is compared with the oldest pending prediction.
	always @(posedge clk) begin
		ufe_pkg::result_t exp;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no request pending: %p", result);
				errors++;
			end else begin
				exp = expected_results.pop_front();
				results_checked++;
				if (result.status)
					rejects_seen++;
				if (result.merged)
					merges_seen++;
				if (result.status !== exp.status) begin
					$error("status: expected %0d, got %0d", exp.status, result.status);
					errors++;
				end
				if (result.same_set !== exp.same_set) begin
					$error("same_set: expected %0d, got %0d", exp.same_set, result.same_set);
					errors++;
				end
				if (result.merged !== exp.merged) begin
					$error("merged: expected %0d, got %0d", exp.merged, result.merged);
					errors++;
				end
				if (result.root_x !== exp.root_x) begin
					$error("root_x: expected %0d, got %0d", exp.root_x, result.root_x);
					errors++;
				end
				if (result.root_y !== exp.root_y) begin
					$error("root_y: expected %0d, got %0d", exp.root_y, result.root_y);
					errors++;
				end
				if (result.components !== exp.components) begin
					$error("components: expected %0d, got %0d", exp.components,
						result.components);
					errors++;
				end
			end
		end
	end

	// Called at a clock edge; returns at the edge where the request is taken.
	task automatic send_request(logic [1:0] op, int x, int y);
		ufe_pkg::request_t rq;
		ufe_pkg::result_t  predicted;
		int                gap;
		rq.opcode = op;
		rq.x = x[ufe_pkg::IDX_W-1:0];
		rq.y = y[ufe_pkg::IDX_W-1:0];
		gap = $urandom_range(0, gap_limit);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= rq;
		do @(posedge clk); while (busy);
		predicted = apply_request(rq);
		expected_results = {expected_results, predicted};
		requests_sent++;
	endtask

	// Waits until every result is in and the engine is free.
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0 || busy);
	endtask

	task automatic set_nodes_in_use(int value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value[ufe_pkg::NIU_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		forest_in_use = value[ufe_pkg::NIU_W-1:0];
		settings_used++;
	endtask

	// Mostly in-range indices; about one in ten may land anywhere.
	task automatic send_random(int count, int union_pct);
		int span;
		int pick;
		int x;
		int y;
		logic [1:0] op;
		span = (forest_in_use > ufe_pkg::NODES) ? ufe_pkg::NODES : int'(forest_in_use);
		if (span < 1)
			span = 1;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < union_pct)
				op = ufe_pkg::OP_UNION;
			else if (pick < union_pct + (100 - union_pct) / 2)
				op = ufe_pkg::OP_QUERY;
			else if (pick < 95)
				op = ufe_pkg::OP_FIND;
			else
				op = OP_RESERVED;
			x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ufe_pkg::NODES - 1)
				: $urandom_range(0, span - 1);
			y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ufe_pkg::NODES - 1)
				: $urandom_range(0, span - 1);
			send_request(op, x, y);
		end
	endtask

	task automatic test_fresh_forest();
		gap_limit = 4;
		send_request(ufe_pkg::OP_FIND, 0, ufe_pkg::NODES - 1);
		send_request(ufe_pkg::OP_FIND, ufe_pkg::NODES - 1, 0);
		send_request(ufe_pkg::OP_QUERY, 0, ufe_pkg::NODES - 1);
		// Equal sizes: the root of x goes under the root of y.
		send_request(ufe_pkg::OP_UNION, 0, 1);
		send_request(ufe_pkg::OP_UNION, 1, 0);
		send_request(ufe_pkg::OP_QUERY, 0, 1);
		send_request(ufe_pkg::OP_UNION, 2, 3);
		send_request(ufe_pkg::OP_UNION, 0, 2);
		// Larger x set absorbs y, then a smaller x set goes under y.
		send_request(ufe_pkg::OP_UNION, 3, 4);
		send_request(ufe_pkg::OP_UNION, 5, 0);
		send_request(OP_RESERVED, 0, 5);
		send_request(ufe_pkg::OP_FIND, 0, 7);
		send_request(ufe_pkg::OP_UNION, ufe_pkg::NODES - 1, ufe_pkg::NODES - 2);
	endtask

	task automatic test_index_limits();
		gap_limit = 2;
		set_nodes_in_use(6);
		send_request(ufe_pkg::OP_UNION, 6, 0);
		send_request(ufe_pkg::OP_QUERY, 0, 6);
		send_request(ufe_pkg::OP_FIND, 5, ufe_pkg::NODES - 1);
		send_request(ufe_pkg::OP_FIND, ufe_pkg::NODES - 1, 0);
		set_nodes_in_use(1);
		send_request(ufe_pkg::OP_FIND, 0, 0);
		send_request(ufe_pkg::OP_QUERY, 0, 1);
		// No element in use, and fewer elements than merges so far.
		set_nodes_in_use(0);
		send_request(ufe_pkg::OP_FIND, 0, 0);
		send_request(ufe_pkg::OP_UNION, 0, 0);
		set_nodes_in_use(2047);
		send_request(ufe_pkg::OP_QUERY, ufe_pkg::NODES - 1, ufe_pkg::NODES - 1);
		send_request(ufe_pkg::OP_UNION, 511, 512);
	endtask

	task automatic test_random_phases();
		set_nodes_in_use(64);
		gap_limit = 4;
		send_random(90, 60);
		gap_limit = 0;
		send_random(60, 60);
		set_nodes_in_use(1024);
		gap_limit = 4;
		send_random(150, 45);
		set_nodes_in_use(2047);
		gap_limit = 0;
		send_random(50, 45);
		set_nodes_in_use(16);
		gap_limit = 4;
		send_random(50, 40);
		set_nodes_in_use(1);
		send_random(20, 40);
		set_nodes_in_use(1024);
		gap_limit = 0;
		send_random(30, 45);
	endtask

	initial begin
		errors = 0;
		requests_sent = 0;
		results_checked = 0;
		merges_seen = 0;
		rejects_seen = 0;
		settings_used = 0;
		cycle_count = 0;
		gap_limit = 0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		for (int i = 0; i < ufe_pkg::NODES; i++) begin
			forest_parent[i] = i[ufe_pkg::IDX_W-1:0];
			forest_size[i] = ufe_pkg::SIZE_W'(1);
		end
		forest_merges = '0;
		forest_in_use = ufe_pkg::NIU_W'(ufe_pkg::NODES);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// The engine clears its memories after reset and holds busy meanwhile.
		wait_idle();
		test_fresh_forest();
		test_index_limits();
		test_random_phases();
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d requests under %0d nodes_in_use settings; %0d results checked.",
			requests_sent, settings_used, results_checked);
		$display("Results included %0d merges and %0d rejected indices.",
			merges_seen, rejects_seen);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("** union_find_engine: PASSED **");
		end else begin
			$display("** union_find_engine: FAILED **");
		end
		$finish;
	end

endmodule

// ===== union_find_engine.f =====
+incdir+rtl/core
rtl/core/ufe_pkg.sv
rtl/core/union_find_engine.sv
tb/tb_union_find_engine.sv
